FILE: rtl/fsba_pkg.sv
// Package for the frame slot bump allocator: sizes, codes, beat and control types.
package fsba_pkg;

	// Slot layout
	localparam int QUEUES     = 4;
	localparam int MAX_FRAMES = 4;
	localparam int SLOTS      = MAX_FRAMES * QUEUES;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Capacity registers: four upload, then four readback
	localparam int CAP_REGS  = 8;
	localparam int CAP_IDX_W = 3;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	// Divider width and width of its step counter
	localparam int DIV_W = 32;
	localparam int CNT_W = $clog2(DIV_W + 1);

	// Operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	// Status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSPACE = 2'd1;
	localparam logic [1:0] STAT_UNSUP   = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [1:0]  frame;
		logic [1:0]  queue;
		logic        upload;
		logic        heap_dynamic;
		logic [31:0] req_size;
		logic [31:0] block_size;
		logic [31:0] offset_align;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] slot_offset;
		logic [31:0] granted_size;
	} out_beat_t;

	// Request to and response from the shared remainder unit
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_DIV1,
		ST_ALIGN,
		ST_DIV2,
		ST_GRANT,
		ST_REPLY
	} state_t;

endpackage

FILE: rtl/fsba_div.sv
// Restoring remainder unit, one quotient bit per cycle, shared by both alignment steps.
module fsba_div
	import fsba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] trial_sub;
	logic           fits;

	// One shift-subtract step
	assign trial     = {rem_q, dvd_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign fits      = trial >= {1'b0, dvs_q};

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend shifter
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/frame_slot_bump_allocator.sv
// Top level of the frame slot bump allocator: registers, slot fills, sequencer.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------
//  in       | in_valid / in_stall         | in_data  (in_beat_t)
//  out      | out_valid / out_stall       | out_data (out_beat_t)
//  config   | psel penable pwrite pready  | paddr pwdata prdata
//
// An allocate beat that reaches the grant step passes idle, load, check, a remainder run
// on the one shared divider, align, a second remainder run, grant and reply. Next-frame,
// dynamic-heap and out-of-range beats go from load straight to reply; a failed fit check
// replies from the check step, an offset past capacity from the align step.
// Reset clears the capacity registers and every slot fill at once.
// in_stall is high while a beat is in work; the reply step waits while out_stall holds back
// an earlier result, and the next beat is taken once the reply is in the output register.
module frame_slot_bump_allocator
	import fsba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_beat_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_beat_t          out_data
);

	state_t state_q, state_d;

	logic [31:0] cap_q [CAP_REGS];
	logic [31:0] fill_up_q [SLOTS];
	logic [31:0] fill_rb_q [SLOTS];

	// Work registers for the beat in hand
	logic        op_q;
	logic [1:0]  frame_q;
	logic [1:0]  queue_q;
	logic        up_q;
	logic        dyn_q;
	logic [31:0] req_q;
	logic [31:0] blk_q;
	logic [31:0] align_q;
	logic [31:0] fill_q;
	logic [31:0] cap_sel_q;
	logic [32:0] off_q;
	logic [31:0] diff_q;
	logic [31:0] room_q;
	logic [31:0] grant_q;
	logic [1:0]  status_q;

	logic        out_valid_q;
	out_beat_t   out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               cfg_wr;
	logic [SLOT_W-1:0]  slot_idx;
	logic [CAP_IDX_W-1:0] cap_idx;
	logic               frame_ok;
	logic               queue_ok;
	logic               fits_blk;
	logic [32:0]        off_calc;
	logic [31:0]        grant_calc;
	logic               out_free;
	logic               set_status;
	logic [1:0]         status_d;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = cap_q[paddr[PADDR_W-1:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAP_REGS; i++) cap_q[i] <= '0;
		end else if (cfg_wr) begin
			cap_q[paddr[PADDR_W-1:2]] <= pwdata;
		end
	end

	// Slot selection
	assign frame_ok = 32'(frame_q) < MAX_FRAMES;
	assign queue_ok = 32'(queue_q) < QUEUES;
	assign slot_idx = SLOT_W'(32'(frame_q) * QUEUES + 32'(queue_q));
	assign cap_idx  = {~up_q, queue_q};

	// Arithmetic on the current step
	assign fits_blk   = ({1'b0, fill_q} + {1'b0, blk_q}) <= {1'b0, cap_sel_q};
	assign off_calc   = (div_rsp.rem == '0) ? {1'b0, fill_q}
	                  : {1'b0, fill_q} + {1'b0, align_q - div_rsp.rem};
	assign grant_calc = (req_q < room_q) ? req_q : room_q;
	assign out_free   = !out_valid_q || !out_stall;

	// Sequencer
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = fill_q;
		div_req.divisor  = align_q;
		set_status       = 1'b0;
		status_d         = STAT_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				set_status = 1'b1;
				if (op_q == OP_FRAME) begin
					status_d = STAT_OK;
					state_d  = ST_REPLY;
				end else if (dyn_q) begin
					status_d = STAT_UNSUP;
					state_d  = ST_REPLY;
				end else if (!frame_ok || !queue_ok) begin
					status_d = STAT_NOSPACE;
					state_d  = ST_REPLY;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!fits_blk) begin
					set_status = 1'b1;
					status_d   = STAT_NOSPACE;
					state_d    = ST_REPLY;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (div_rsp.done) state_d = ST_ALIGN;
			end
			ST_ALIGN: begin
				div_req.dividend = diff_q;
				div_req.divisor  = blk_q;
				if (off_q > {1'b0, cap_sel_q}) begin
					set_status = 1'b1;
					status_d   = STAT_NOSPACE;
					state_d    = ST_REPLY;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (div_rsp.done) state_d = ST_GRANT;
			end
			ST_GRANT: begin
				set_status = 1'b1;
				status_d   = (grant_calc == '0) ? STAT_NOSPACE : STAT_OK;
				state_d    = ST_REPLY;
			end
			ST_REPLY: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign in_stall = state_q != ST_IDLE;

	// Datapath work registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q    <= in_data.operation;
			frame_q <= in_data.frame;
			queue_q <= in_data.queue;
			up_q    <= in_data.upload;
			dyn_q   <= in_data.heap_dynamic;
			req_q   <= in_data.req_size;
			blk_q   <= (in_data.block_size == '0) ? 32'd1 : in_data.block_size;
			align_q <= (in_data.offset_align == '0) ? 32'd1 : in_data.offset_align;
		end
		if (state_q == ST_LOAD) begin
			fill_q    <= up_q ? fill_up_q[slot_idx] : fill_rb_q[slot_idx];
			cap_sel_q <= cap_q[cap_idx];
		end
		if (state_q == ST_DIV1 && div_rsp.done) begin
			off_q  <= off_calc;
			diff_q <= cap_sel_q - off_calc[31:0];
		end
		if (state_q == ST_DIV2 && div_rsp.done) begin
			room_q <= diff_q - div_rsp.rem;
		end
		if (state_q == ST_GRANT) begin
			grant_q <= grant_calc;
		end
		if (set_status) begin
			status_q <= status_d;
		end
	end

	// Slot fills: bump on a grant, clear a whole frame on next-frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				fill_up_q[i] <= '0;
				fill_rb_q[i] <= '0;
			end
		end else if (state_q == ST_REPLY && out_free) begin
			if (op_q == OP_FRAME) begin
				if (frame_ok) begin
					for (int q = 0; q < QUEUES; q++) begin
						fill_up_q[SLOT_W'(32'(frame_q) * QUEUES + q)] <= '0;
						fill_rb_q[SLOT_W'(32'(frame_q) * QUEUES + q)] <= '0;
					end
				end
			end else if (!dyn_q && status_q == STAT_OK) begin
				if (up_q) fill_up_q[slot_idx] <= off_q[31:0] + grant_q;
				else      fill_rb_q[slot_idx] <= off_q[31:0] + grant_q;
			end
		end
	end

	// Shared remainder unit
	fsba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_REPLY && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REPLY && out_free) begin
			out_q.status <= status_q;
			if (op_q == OP_ALLOC && status_q == STAT_OK) begin
				out_q.slot_offset  <= off_q[31:0];
				out_q.granted_size <= grant_q;
			end else begin
				out_q.slot_offset  <= '0;
				out_q.granted_size <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STAT_OK
		|-> out_data.granted_size == '0 && out_data.slot_offset == '0)
		else $error("failed beat carries a grant");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == ST_CHECK || state_q == ST_ALIGN))
		else $error("divider started outside an alignment step");

	a_reply_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_REPLY))
		else $error("result raised without a reply step");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while one is in work");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the frame slot bump allocator.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fsba_pkg::*;

	// Capacity register layout: four upload queues, then four readback queues
	localparam int WRITE_CAP_BASE = 0;
	localparam int READ_CAP_BASE  = 4;
	localparam int REG_STRIDE     = 4;
	localparam int REPLY_LATENCY  = 100;
	localparam int CYCLE_LIMIT    = 1500000;
	localparam int PRINT_LIMIT    = 100;

	typedef logic [CAP_REGS-1:0][31:0] cap_set_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_beat_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_beat_t          out_data;

	// Shadow of the block: capacities and per-slot fill levels
	logic [31:0] cap_shadow [CAP_REGS];
	logic [31:0] upload_level [SLOTS];
	logic [31:0] readback_level [SLOTS];

	out_beat_t awaited_replies [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        sender_gap_pct = 0;
	int        receiver_stall_pct = 0;

	frame_slot_bump_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Expected reply for one accepted beat; updates the shadow fill levels
	function automatic out_beat_t alloc_outcome(input in_beat_t b);
		out_beat_t   r;
		logic [63:0] fill, cap, blk, algn, off, room, grant;
		int          slot, q;
		r = '0;
		r.status = STAT_OK;
		if (b.operation == OP_FRAME) begin
			if (int'(b.frame) < MAX_FRAMES) begin
				for (q = 0; q < QUEUES; q++) begin
					upload_level[int'(b.frame) * QUEUES + q] = '0;
					readback_level[int'(b.frame) * QUEUES + q] = '0;
				end
			end
			return r;
		end
		if (b.heap_dynamic) begin
			r.status = STAT_UNSUP;
			return r;
		end
		if (int'(b.frame) >= MAX_FRAMES || int'(b.queue) >= QUEUES) begin
			r.status = STAT_NOSPACE;
			return r;
		end
		blk  = (b.block_size == 0) ? 64'd1 : 64'(b.block_size);
		algn = (b.offset_align == 0) ? 64'd1 : 64'(b.offset_align);
		slot = int'(b.frame) * QUEUES + int'(b.queue);
		fill = b.upload ? 64'(upload_level[slot]) : 64'(readback_level[slot]);
		cap  = b.upload ? 64'(cap_shadow[WRITE_CAP_BASE + int'(b.queue)])
		                : 64'(cap_shadow[READ_CAP_BASE + int'(b.queue)]);
		if (fill + blk > cap) begin
			r.status = STAT_NOSPACE;
			return r;
		end
		off = ((fill + algn - 64'd1) / algn) * algn;
		if (off > cap) begin
			r.status = STAT_NOSPACE;
			return r;
		end
		room  = ((cap - off) / blk) * blk;
		grant = (64'(b.req_size) < room) ? 64'(b.req_size) : room;
		if (grant == 0) begin
			r.status = STAT_NOSPACE;
			return r;
		end
		if (b.upload)
			upload_level[slot] = 32'(off + grant);
		else
			readback_level[slot] = 32'(off + grant);
		r.slot_offset  = off[31:0];
		r.granted_size = grant[31:0];
		return r;
	endfunction

	// Receiver stall pattern
	always @(posedge clk)
		out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);

	// Reply checker: each accepted beat against the oldest expectation
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_replies.size() == 0) begin
				report_mismatch("reply with nothing awaited", 32'(out_data.status), '0);
			end else begin
				want = awaited_replies.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.slot_offset !== want.slot_offset)
					report_mismatch("slot_offset", out_data.slot_offset, want.slot_offset);
				if (out_data.granted_size !== want.granted_size)
					report_mismatch("granted_size", out_data.granted_size,
						want.granted_size);
			end
		end
	end

	// One APB transfer; bus is left driven so a following transfer can start at once
	task automatic apb_transfer(input bit wr, input int idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'(idx * REG_STRIDE);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
	endtask

	// Write every capacity register, then read each one back
	task automatic program_caps(input cap_set_t caps);
		logic [31:0] rd;
		int          i;
		for (i = 0; i < CAP_REGS; i++) begin
			apb_transfer(1'b1, i, caps[i], rd);
			cap_shadow[i] = caps[i];
		end
		for (i = 0; i < CAP_REGS; i++) begin
			apb_transfer(1'b0, i, '0, rd);
			if (rd !== cap_shadow[i])
				report_mismatch("capacity readback", rd, cap_shadow[i]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Send one beat, with random idle cycles before it; valid stays high afterwards
	task automatic send_beat(input in_beat_t b);
		while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		awaited_replies.push_back(alloc_outcome(b));
	endtask

	// Stop sending and wait until every reply is back
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic in_beat_t alloc_beat(input logic [1:0] frame, input logic [1:0] queue,
			input logic upload, input logic [31:0] req, input logic [31:0] blk,
			input logic [31:0] algn);
		in_beat_t b;
		b.operation    = OP_ALLOC;
		b.frame        = frame;
		b.queue        = queue;
		b.upload       = upload;
		b.heap_dynamic = 1'b0;
		b.req_size     = req;
		b.block_size   = blk;
		b.offset_align = algn;
		return b;
	endfunction

	function automatic in_beat_t frame_beat(input logic [1:0] frame);
		in_beat_t b;
		b = alloc_beat(frame, 2'($urandom), 1'($urandom), $urandom, $urandom, $urandom);
		b.operation    = OP_FRAME;
		b.heap_dynamic = 1'($urandom);
		return b;
	endfunction

	// Byte count biased to small values, with zero, powers of two and full range
	function automatic logic [31:0] random_amount(input int small_max);
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		if (pick < 20)
			return $urandom;
		if (pick < 35)
			return 32'd1 << $urandom_range(12);
		return $urandom_range(small_max, 1);
	endfunction

	function automatic logic [31:0] random_cap();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(8192, 1);
		endcase
	endfunction

	function automatic in_beat_t random_beat();
		in_beat_t b;
		b = alloc_beat(2'($urandom), 2'($urandom), 1'($urandom), random_amount(600),
			random_amount(16), random_amount(64));
		b.heap_dynamic = ($urandom_range(99) < 6);
		if ($urandom_range(99) < 8)
			b.operation = OP_FRAME;
		return b;
	endfunction

	// Register access: extremes and patterns, each read back
	task automatic test_cap_registers();
		cap_set_t caps;
		caps = '{32'hFFFF_FFFF, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
		         32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
		program_caps(caps);
		caps = ~caps;
		program_caps(caps);
	endtask

	// Directed beats: extremes, both operations and each corner of the grant rules
	task automatic test_special_cases();
		cap_set_t caps;
		in_beat_t b;
		// index CAP_REGS-1 first: upload q0..q3 are the low entries
		caps = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'd4096,
		         32'd1000, 32'd110, 32'h0, 32'hFFFF_FFFF};
		program_caps(caps);
		// dynamic heap is refused
		b = alloc_beat(2'd0, 2'd0, 1'b1, 32'd16, 32'd1, 32'd1);
		b.heap_dynamic = 1'b1;
		send_beat(b);
		// whole 32-bit slot in one grant, then nothing is left
		send_beat(alloc_beat(2'd0, 2'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_beat(alloc_beat(2'd0, 2'd0, 1'b1, 32'd1, 32'd1, 32'd1));
		send_beat(frame_beat(2'd0));
		// zero block size and zero alignment act as one
		send_beat(alloc_beat(2'd0, 2'd0, 1'b1, 32'd1, 32'd0, 32'd0));
		// alignment sum runs past 32 bits
		send_beat(alloc_beat(2'd0, 2'd0, 1'b1, 32'd10, 32'd1, 32'hFFFF_FFFF));
		send_beat(alloc_beat(2'd0, 2'd0, 1'b1, 32'd10, 32'd1, 32'h8000_0000));
		// zero capacity
		send_beat(alloc_beat(2'd1, 2'd1, 1'b1, 32'd1, 32'd1, 32'd1));
		// aligned offset lands past the capacity
		send_beat(alloc_beat(2'd2, 2'd2, 1'b1, 32'd100, 32'd1, 32'd1));
		send_beat(alloc_beat(2'd2, 2'd2, 1'b1, 32'd5, 32'd1, 32'd128));
		// zero request
		send_beat(alloc_beat(2'd3, 2'd3, 1'b1, 32'd0, 32'd1, 32'd1));
		// room rounded down to the block size, then a partial block after alignment
		send_beat(alloc_beat(2'd3, 2'd3, 1'b1, 32'd999, 32'd7, 32'd4));
		send_beat(alloc_beat(2'd3, 2'd3, 1'b1, 32'd3, 32'd4, 32'd2));
		// readback set
		send_beat(alloc_beat(2'd3, 2'd2, 1'b0, 32'd5, 32'd1, 32'd1));
		send_beat(alloc_beat(2'd3, 2'd2, 1'b0, 32'd5, 32'd1, 32'd1));
		send_beat(alloc_beat(2'd1, 2'd1, 1'b0, 32'hFFFF_FFFF, 32'd2, 32'd1));
		send_beat(alloc_beat(2'd0, 2'd3, 1'b0, 32'd1, 32'd1, 32'd1));
		send_beat(alloc_beat(2'd0, 2'd0, 1'b0, 32'd4097, 32'd1, 32'd1));
		// next frame clears both sets of that frame only
		send_beat(frame_beat(2'd3));
		send_beat(alloc_beat(2'd3, 2'd2, 1'b0, 32'd5, 32'd1, 32'd1));
		send_beat(alloc_beat(2'd3, 2'd3, 1'b1, 32'd1000, 32'd1, 32'd1));
		send_beat(alloc_beat(2'd1, 2'd1, 1'b0, 32'd1, 32'd1, 32'd1));
		send_beat(frame_beat(2'd1));
		send_beat(alloc_beat(2'd1, 2'd1, 1'b0, 32'd1, 32'd1, 32'd1));
		drain_replies();
	endtask

	// Random traffic under one idle pattern and one capacity setting
	task automatic test_random_traffic(input int phase, input int gap_pct,
			input int stall_pct, input int beats);
		cap_set_t caps;
		int       i;
		for (i = 0; i < CAP_REGS; i++)
			caps[i] = random_cap();
		// make sure the extremes turn up in some register
		if (phase == 0) begin
			caps[WRITE_CAP_BASE] = '0;
			caps[READ_CAP_BASE + 3] = '1;
		end else if (phase == 1) begin
			caps[WRITE_CAP_BASE + 3] = '1;
			caps[READ_CAP_BASE] = '0;
		end
		program_caps(caps);
		sender_gap_pct     = gap_pct;
		receiver_stall_pct = stall_pct;
		for (i = 0; i < beats; i++)
			send_beat(random_beat());
		drain_replies();
	endtask

	initial begin
		int i;
		for (i = 0; i < CAP_REGS; i++)
			cap_shadow[i] = '0;
		for (i = 0; i < SLOTS; i++) begin
			upload_level[i]   = '0;
			readback_level[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cap_registers();
		test_special_cases();
		test_random_traffic(0, 33, 82, 700);
		test_random_traffic(1, 82, 33, 700);
		test_random_traffic(2, 0, 0, 700);

		receiver_stall_pct = 0;
		repeat (REPLY_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
